FILE: hw/rtl/mspt_pkg.sv
// ----------------------------------------------------------------------------
// mspt_pkg
// Shared types and constants for the step position tracker.
// ----------------------------------------------------------------------------
package mspt_pkg;

  localparam int FIELD_W = 24;
  localparam int REG_W   = 12;
  localparam int MASK_W  = 4;

  typedef enum logic [1:0] {
    KIND_ABS_SET  = 2'd0,
    KIND_REL_MOVE = 2'd1,
    KIND_SCAN     = 2'd2,
    KIND_PULSE    = 2'd3
  } kind_t;

  // Axis indexes
  localparam int AX_X = 1;
  localparam int AX_Y = 2;
  localparam int AX_Z = 3;

  // Register indexes
  localparam logic [1:0] CFG_X_BACKLASH = 2'd0;
  localparam logic [1:0] CFG_Y_BACKLASH = 2'd1;
  localparam logic [1:0] CFG_Y_DEADBAND = 2'd2;

  localparam logic [REG_W-1:0] X_BACKLASH_RST = 12'd81;
  localparam logic [REG_W-1:0] Y_BACKLASH_RST = 12'd84;
  localparam logic [REG_W-1:0] Y_DEADBAND_RST = 12'd200;

  typedef struct packed {
    logic [REG_W-1:0] x_backlash;
    logic [REG_W-1:0] y_backlash;
    logic [REG_W-1:0] y_deadband;
  } cfg_t;

  typedef struct packed {
    kind_t                     kind;
    logic [1:0]                axis_sel;
    logic signed [FIELD_W-1:0] delta_steps;
    logic signed [FIELD_W-1:0] x_target;
    logic signed [FIELD_W-1:0] y_target;
    logic signed [FIELD_W-1:0] z_target;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0]         enable_mask;
    logic [MASK_W-1:0]         direction_mask;
    logic signed [FIELD_W-1:0] axis_position;
    logic                      axis_at_target;
  } res_t;

endpackage

FILE: hw/rtl/multi_axis_step_position_tracker.sv
// ----------------------------------------------------------------------------
// multi_axis_step_position_tracker
// Target and actual step counts per axis, with backlash compensation.
// ----------------------------------------------------------------------------
// Command words come in on the in_ channel (in_valid / in_stall), one result
// word per command leaves on the out_ channel (out_valid / out_stall). A word
// moves at an edge with valid high and stall low.
// Kinds: absolute set of X/Y/Z with backlash fix-up on X (no deadband) and
// Y (deadband), relative move of one target, scan of all axes, pulse event.
// Flow: a command taken lands in the input register; the axis state and
// result register update together when it is processed, once the result
// register is free. Throughput: one command per cycle while the receiver
// does not stall, set by the update of the per-axis count registers.
// When the receiver stalls, the result holds in the output register and one
// further command can still be taken into the input register; in_stall rises
// only once both registers are full.
// Backlash and deadband registers are written through cfg_we / cfg_index /
// cfg_data, by the user only while idle (unenforced); unmapped indexes drop.
// Reset (rst, synchronous): counts zero, all drivers off, pull direction,
// backlash 81 / 84 and deadband 200 steps, both channels empty.
// ----------------------------------------------------------------------------
module multi_axis_step_position_tracker #(
  parameter int AXES          = 4,
  parameter int POSITION_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          kind,
  input  logic [1:0]                          axis_sel,
  input  logic signed [mspt_pkg::FIELD_W-1:0] delta_steps,
  input  logic signed [mspt_pkg::FIELD_W-1:0] x_target,
  input  logic signed [mspt_pkg::FIELD_W-1:0] y_target,
  input  logic signed [mspt_pkg::FIELD_W-1:0] z_target,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mspt_pkg::MASK_W-1:0]         enable_mask,
  output logic [mspt_pkg::MASK_W-1:0]         direction_mask,
  output logic signed [mspt_pkg::FIELD_W-1:0] axis_position,
  output logic                                axis_at_target,
  // configuration
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [mspt_pkg::REG_W-1:0]          cfg_data
);

  // Bits of the reported masks that can belong to a real axis
  localparam logic [7:0] LIVE_MASK = 8'((16'd1 << AXES) - 16'd1);

  mspt_pkg::cfg_t  cfg;
  mspt_pkg::item_t item;
  mspt_pkg::res_t  res_next;
  logic            in_full;
  logic            advance;

  // per-axis state
  logic [AXES-1:0][POSITION_BITS-1:0] target;
  logic [AXES-1:0][POSITION_BITS-1:0] actual;
  logic [AXES-1:0]                    enabled;
  logic [AXES-1:0]                    direction;
  logic [AXES-1:0][POSITION_BITS-1:0] target_next;
  logic [AXES-1:0][POSITION_BITS-1:0] actual_next;
  logic [AXES-1:0]                    enabled_next;
  logic [AXES-1:0]                    direction_next;

  mspt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held command is processed as soon as the result register is free.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.kind        <= mspt_pkg::kind_t'(kind);
      item.axis_sel    <= axis_sel;
      item.delta_steps <= delta_steps;
      item.x_target    <= x_target;
      item.y_target    <= y_target;
      item.z_target    <= z_target;
    end
  end

  mspt_axis_update #(
    .AXES          (AXES),
    .POSITION_BITS (POSITION_BITS)
  ) u_update (
    .item           (item),
    .cfg            (cfg),
    .target         (target),
    .actual         (actual),
    .enabled        (enabled),
    .direction      (direction),
    .target_next    (target_next),
    .actual_next    (actual_next),
    .enabled_next   (enabled_next),
    .direction_next (direction_next),
    .res            (res_next)
  );

  // axis state commits together with the result
  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= '0;
      actual    <= '0;
      enabled   <= '0;
      direction <= '0;
    end else if (advance) begin
      target    <= target_next;
      actual    <= actual_next;
      enabled   <= enabled_next;
      direction <= direction_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      enable_mask    <= res_next.enable_mask;
      direction_mask <= res_next.direction_mask;
      axis_position  <= res_next.axis_position;
      axis_at_target <= res_next.axis_at_target;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled with room downstream");

  a_result_follows_advance: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed command gave no result");

  a_state_holds_when_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(actual) && $stable(target) && $stable(enabled)))
    else $error("axis state changed without a command");

  a_no_ghost_axes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (((enable_mask | direction_mask) & ~LIVE_MASK[3:0]) == 4'd0))
    else $error("mask bit set for a missing axis");

endmodule

FILE: hw/rtl/mspt_cfg.sv
// ----------------------------------------------------------------------------
// mspt_cfg
// Backlash and deadband register file with a plain write port.
// ----------------------------------------------------------------------------
module mspt_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [mspt_pkg::REG_W-1:0] cfg_data,
  output mspt_pkg::cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_backlash <= mspt_pkg::X_BACKLASH_RST;
      cfg.y_backlash <= mspt_pkg::Y_BACKLASH_RST;
      cfg.y_deadband <= mspt_pkg::Y_DEADBAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mspt_pkg::CFG_X_BACKLASH: cfg.x_backlash <= cfg_data;
        mspt_pkg::CFG_Y_BACKLASH: cfg.y_backlash <= cfg_data;
        mspt_pkg::CFG_Y_DEADBAND: cfg.y_deadband <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

endmodule

FILE: hw/rtl/mspt_axis_update.sv
// ----------------------------------------------------------------------------
// mspt_axis_update
// Next-state and result logic for one command word over all axes.
// ----------------------------------------------------------------------------
module mspt_axis_update #(
  parameter int AXES          = 4,
  parameter int POSITION_BITS = 24
) (
  input  mspt_pkg::item_t                        item,
  input  mspt_pkg::cfg_t                         cfg,
  input  logic [AXES-1:0][POSITION_BITS-1:0]     target,
  input  logic [AXES-1:0][POSITION_BITS-1:0]     actual,
  input  logic [AXES-1:0]                        enabled,
  input  logic [AXES-1:0]                        direction,
  output logic [AXES-1:0][POSITION_BITS-1:0]     target_next,
  output logic [AXES-1:0][POSITION_BITS-1:0]     actual_next,
  output logic [AXES-1:0]                        enabled_next,
  output logic [AXES-1:0]                        direction_next,
  output mspt_pkg::res_t                         res
);

  localparam int PB = POSITION_BITS;
  localparam int EW = ((PB > mspt_pkg::FIELD_W) ? PB : mspt_pkg::FIELD_W) + 2;
  localparam logic signed [EW-1:0] PMAX = EW'((64'sd1 <<< (PB - 1)) - 64'sd1);
  localparam logic signed [EW-1:0] PMIN = -PMAX - EW'(1);

  function automatic logic [PB-1:0] clamp(input logic signed [EW-1:0] v);
    if (v > PMAX) return PMAX[PB-1:0];
    if (v < PMIN) return PMIN[PB-1:0];
    return v[PB-1:0];
  endfunction

  logic [7:0] en_pad;
  logic [7:0] dir_pad;

  always_comb begin
    logic signed [EW-1:0] a;
    logic signed [EW-1:0] t;
    logic signed [EW-1:0] bx;
    logic signed [EW-1:0] by;
    logic signed [EW-1:0] d;
    logic                 sel;
    bx = signed'(EW'(cfg.x_backlash));
    by = signed'(EW'(cfg.y_backlash));
    d  = signed'(EW'(cfg.y_deadband));
    target_next    = target;
    actual_next    = actual;
    enabled_next   = enabled;
    direction_next = direction;
    for (int i = 0; i < AXES; i++) begin
      sel = (int'(item.axis_sel) == i);
      a = EW'(signed'(actual[i]));
      t = EW'(signed'(target[i]));
      case (item.kind)
        mspt_pkg::KIND_ABS_SET: begin
          if (i == mspt_pkg::AX_X) begin
            t = EW'(signed'(clamp(EW'(item.x_target))));
            target_next[i] = t[PB-1:0];
            if (a < t) actual_next[i] = clamp(a - bx);
            else if (a > t) actual_next[i] = clamp(a + bx);
          end else if (i == mspt_pkg::AX_Y) begin
            t = EW'(signed'(clamp(EW'(item.y_target))));
            target_next[i] = t[PB-1:0];
            if (a + d < t) actual_next[i] = clamp(a - by);
            else if (a - d > t) actual_next[i] = clamp(a + by);
          end else if (i == mspt_pkg::AX_Z) begin
            target_next[i] = clamp(EW'(item.z_target));
          end
        end
        mspt_pkg::KIND_REL_MOVE: begin
          if (sel) target_next[i] = clamp(t + EW'(item.delta_steps));
        end
        mspt_pkg::KIND_SCAN: begin
          if (a != t) begin
            direction_next[i] = (a < t);
            enabled_next[i]   = 1'b1;
          end
        end
        mspt_pkg::KIND_PULSE: begin
          if (sel && enabled[i]) begin
            if (a == t) enabled_next[i] = 1'b0;
            else if (a < t) actual_next[i] = actual[i] + PB'(1);
            else actual_next[i] = actual[i] - PB'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    en_pad  = 8'(enabled_next);
    dir_pad = 8'(direction_next);
    res.enable_mask    = en_pad[mspt_pkg::MASK_W-1:0];
    res.direction_mask = dir_pad[mspt_pkg::MASK_W-1:0];
    res.axis_position  = '0;
    res.axis_at_target = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      if (int'(item.axis_sel) == i) begin
        res.axis_position  = mspt_pkg::FIELD_W'(signed'(actual_next[i]));
        res.axis_at_target = (actual_next[i] == target_next[i]);
      end
    end
  end

endmodule

FILE: dv/tb_multi_axis_step_position_tracker.sv
// ----------------------------------------------------------------------------
// tb_multi_axis_step_position_tracker
// Self-checking bench for the four-axis step position tracker.
// ----------------------------------------------------------------------------
// Command words are pushed through the valid/stall input channel with random
// gaps. A shadow copy of the per-axis counts, enables and directions is
// updated as each word is accepted, and the result it should produce is
// queued. Every accepted result word is compared field by field against the
// oldest queued expectation. The run walks through directed corner cases,
// constrained random sequences under several backlash/deadband settings,
// repeated full-scale backlash in both directions, and a long result hold-off.
// ----------------------------------------------------------------------------
module tb_multi_axis_step_position_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [mspt_pkg::FIELD_W-1:0] pos_t;
  typedef logic [mspt_pkg::REG_W-1:0]          regval_t;

  localparam int         STALL_LIMIT  = 1000;
  localparam int         HOLD_CYCLES  = 80;
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam pos_t       POS_MAX      = {1'b0, {(mspt_pkg::FIELD_W-1){1'b1}}};
  localparam pos_t       POS_MIN      = {1'b1, {(mspt_pkg::FIELD_W-1){1'b0}}};
  localparam regval_t    REG_FULL     = {mspt_pkg::REG_W{1'b1}};

  // DUT connections; every input starts at a known value
  logic                        clk            = 1'b0;
  logic                        rst            = 1'b1;
  logic                        in_valid       = 1'b0;
  logic                        in_stall;
  logic [1:0]                  kind           = '0;
  logic [1:0]                  axis_sel       = '0;
  pos_t                        delta_steps    = '0;
  pos_t                        x_target       = '0;
  pos_t                        y_target       = '0;
  pos_t                        z_target       = '0;
  logic                        out_valid;
  logic                        out_stall      = 1'b0;
  logic [mspt_pkg::MASK_W-1:0] enable_mask;
  logic [mspt_pkg::MASK_W-1:0] direction_mask;
  pos_t                        axis_position;
  logic                        axis_at_target;
  logic                        cfg_we         = 1'b0;
  logic [1:0]                  cfg_index      = '0;
  regval_t                     cfg_data       = '0;

  // Shadow of the tracker state, as it stands after the last accepted word
  pos_t       tgt_pos [4] = '{default: '0};
  pos_t       act_pos [4] = '{default: '0};
  logic [3:0] drv_en  = '0;
  logic [3:0] drv_dir = '0;
  regval_t    x_bl    = mspt_pkg::X_BACKLASH_RST;
  regval_t    y_bl    = mspt_pkg::Y_BACKLASH_RST;
  regval_t    y_db    = mspt_pkg::Y_DEADBAND_RST;

  mspt_pkg::res_t expected_reports[$];

  int  errors        = 0;
  int  n_words       = 0;
  int  n_checked     = 0;
  int  kind_count[4] = '{default: 0};
  int  hold_request  = 0;  // bumped to ask rx_side for a receiver hold-off
  int  quiet_cycles  = 0;
  bit  steady        = 1'b0;  // when set neither side idles

  multi_axis_step_position_tracker u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic pos_t sat24(longint v);
    if (v > longint'(POS_MAX)) return POS_MAX;
    if (v < longint'(POS_MIN)) return POS_MIN;
    return v[mspt_pkg::FIELD_W-1:0];
  endfunction

  // Applies one command word to the shadow state and returns the result word
  // the tracker should report for it.
  function automatic mspt_pkg::res_t track_word(mspt_pkg::kind_t k, logic [1:0] ax,
                                                pos_t dl, pos_t xt, pos_t yt,
                                                pos_t zt);
    mspt_pkg::res_t r;
    longint         a;
    longint         t;
    longint         d;
    case (k)
      mspt_pkg::KIND_ABS_SET: begin
        tgt_pos[mspt_pkg::AX_X] = xt;
        tgt_pos[mspt_pkg::AX_Y] = yt;
        tgt_pos[mspt_pkg::AX_Z] = zt;
        // X: backlash taken up on any move to a different target, no deadband
        a = act_pos[mspt_pkg::AX_X];
        t = tgt_pos[mspt_pkg::AX_X];
        if (a < t) a = a - longint'(x_bl);
        else if (a > t) a = a + longint'(x_bl);
        act_pos[mspt_pkg::AX_X] = sat24(a);
        // Y: only when the move is longer than the deadband
        a = act_pos[mspt_pkg::AX_Y];
        t = tgt_pos[mspt_pkg::AX_Y];
        d = longint'(y_db);
        if (a + d < t) a = a - longint'(y_bl);
        else if (a - d > t) a = a + longint'(y_bl);
        act_pos[mspt_pkg::AX_Y] = sat24(a);
      end
      mspt_pkg::KIND_REL_MOVE: tgt_pos[ax] = sat24(longint'(tgt_pos[ax]) + longint'(dl));
      mspt_pkg::KIND_SCAN: begin
        for (int i = 0; i < 4; i++) begin
          if (act_pos[i] != tgt_pos[i]) begin
            drv_dir[i] = act_pos[i] < tgt_pos[i];
            drv_en[i]  = 1'b1;
          end
        end
      end
      default: begin
        // pulse: disabled axes ignore it
        if (drv_en[ax]) begin
          if (act_pos[ax] == tgt_pos[ax]) drv_en[ax] = 1'b0;
          else if (act_pos[ax] < tgt_pos[ax]) act_pos[ax] = act_pos[ax] + pos_t'(1);
          else act_pos[ax] = act_pos[ax] - pos_t'(1);
        end
      end
    endcase
    r.enable_mask    = drv_en;
    r.direction_mask = drv_dir;
    r.axis_position  = act_pos[ax];
    r.axis_at_target = act_pos[ax] == tgt_pos[ax];
    return r;
  endfunction

  // ---------------------------------------------------------------- sender
  // Leaves in_valid high after acceptance so back-to-back words need no
  // extra edge; wait_drained is what finally drops it.
  task automatic send_word(mspt_pkg::kind_t k, logic [1:0] ax, pos_t dl,
                           pos_t xt, pos_t yt, pos_t zt);
    while (!steady && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    axis_sel    <= ax;
    delta_steps <= dl;
    x_target    <= xt;
    y_target    <= yt;
    z_target    <= zt;
    do @(posedge clk); while (in_stall);
    expected_reports.push_back(track_word(k, ax, dl, xt, yt, zt));
    n_words++;
    kind_count[k]++;
  endtask

  function automatic pos_t rnd24();
    logic [31:0] raw;
    raw = $urandom;
    return pos_t'(raw[mspt_pkg::FIELD_W-1:0]);
  endfunction

  // Unused fields carry junk so the block is seen to ignore them
  task automatic do_abs(logic [1:0] ax, pos_t xt, pos_t yt, pos_t zt);
    send_word(mspt_pkg::KIND_ABS_SET, ax, rnd24(), xt, yt, zt);
  endtask

  task automatic do_move(logic [1:0] ax, pos_t dl);
    send_word(mspt_pkg::KIND_REL_MOVE, ax, dl, rnd24(), rnd24(), rnd24());
  endtask

  task automatic do_scan(logic [1:0] ax);
    send_word(mspt_pkg::KIND_SCAN, ax, rnd24(), rnd24(), rnd24(), rnd24());
  endtask

  task automatic do_pulse(logic [1:0] ax);
    send_word(mspt_pkg::KIND_PULSE, ax, rnd24(), rnd24(), rnd24(), rnd24());
  endtask

  // Drops valid and waits for every outstanding result word
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Drains first; the unmapped index must be dropped
  task automatic program_regs(regval_t xb, regval_t yb, regval_t db);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= mspt_pkg::CFG_X_BACKLASH;
    cfg_data  <= xb;
    @(posedge clk);
    cfg_index <= mspt_pkg::CFG_Y_BACKLASH;
    cfg_data  <= yb;
    @(posedge clk);
    cfg_index <= mspt_pkg::CFG_Y_DEADBAND;
    cfg_data  <= db;
    @(posedge clk);
    cfg_index <= CFG_UNMAPPED;
    cfg_data  <= mspt_pkg::REG_W'($urandom);
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    x_bl = xb;
    y_bl = yb;
    y_db = db;
  endtask

  // ---------------------------------------------------------------- random
  // Signed offset: mostly short so pulses can reach the target and cross the
  // deadband, sometimes anywhere in the field.
  function automatic longint rnd_offset();
    longint off;
    case ($urandom_range(3))
      0:       off = longint'($urandom_range(6));
      1:       off = longint'($urandom_range(60));
      2:       off = longint'($urandom_range(5000));
      default: return longint'(rnd24());
    endcase
    return $urandom_range(1) ? -off : off;
  endfunction

  // Mostly an enabled axis, otherwise any
  function automatic logic [1:0] pick_axis();
    logic [1:0] a;
    a = 2'($urandom_range(3));
    if (drv_en != 0 && $urandom_range(99) < 85)
      while (!drv_en[a]) a = 2'($urandom_range(3));
    return a;
  endfunction

  // Sequences of: set or move near the current counts, scan, then a run of
  // pulses. Some words are pure noise. Ignored pulses are not counted.
  task automatic run_random(int n_target);
    int              done;
    int              r;
    logic [1:0]      ax;
    mspt_pkg::kind_t k;
    done = 0;
    while (done < n_target) begin
      r = $urandom_range(99);
      if (r < 35) begin
        do_abs(2'($urandom_range(3)),
               sat24(longint'(act_pos[mspt_pkg::AX_X]) + rnd_offset()),
               sat24(longint'(act_pos[mspt_pkg::AX_Y]) + rnd_offset()),
               sat24(longint'(act_pos[mspt_pkg::AX_Z]) + rnd_offset()));
        done++;
      end else if (r < 65) begin
        do_move(2'($urandom_range(3)), sat24(rnd_offset()));
        done++;
      end else if (r < 75) begin
        ax = 2'($urandom_range(3));
        k  = mspt_pkg::kind_t'(2'($urandom_range(3)));
        if (!(k == mspt_pkg::KIND_PULSE && !drv_en[ax])) done++;
        send_word(k, ax, rnd24(), rnd24(), rnd24(), rnd24());
      end
      do_scan(2'($urandom_range(3)));
      done++;
      repeat ($urandom_range(1, 24)) begin
        ax = pick_axis();
        if (drv_en[ax]) done++;
        do_pulse(ax);
      end
      // now and then the sender waits for everything to come back
      if ($urandom_range(99) < 3) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    do_pulse(2'd0);                 // pump disabled: nothing moves
    do_move(2'd0, 24'sd2);
    do_scan(2'd0);
    repeat (3) do_pulse(2'd0);      // two steps up, then off at target
    do_scan(2'd1);                  // all on target: scan changes nothing
    do_abs(2'd1, 24'sd100, 24'sd100, -24'sd5);   // Y move inside the deadband
    do_abs(2'd2, 24'sd100, 24'sd1000, -24'sd5);  // Y long move up
    do_abs(2'd2, 24'sd100, -24'sd1000, -24'sd5); // Y long move down
    do_abs(2'd3, POS_MIN, POS_MAX, POS_MAX);     // extreme targets
    do_move(2'd3, POS_MAX);         // saturates high
    do_move(2'd3, POS_MIN);
    do_move(2'd3, POS_MIN);         // saturates low
    do_move(2'd2, POS_MIN);
    do_move(2'd1, POS_MAX);
    do_scan(2'd0);
    do_pulse(2'd0);
    do_pulse(2'd1);
    do_pulse(2'd2);
    do_pulse(2'd3);
    do_move(2'd0, -24'sd1);
    do_scan(2'd2);
    do_pulse(2'd0);                 // pull direction
    do_pulse(2'd0);
    do_pulse(2'd0);                 // already switched off at target: ignored
  endtask

  task automatic test_steady_stream();
    steady = 1'b1;
    run_random(80);
    wait_drained();
    steady = 1'b0;
  endtask

  task automatic test_register_extremes();
    program_regs('0, '0, '0);
    run_random(110);
    program_regs(REG_FULL, REG_FULL, REG_FULL);
    run_random(100);
  endtask

  // Full-scale backlash applied again and again drives X and Y a long way
  // down and then back up past zero.
  task automatic test_backlash_full_scale();
    program_regs(REG_FULL, REG_FULL, 12'd0);
    repeat (40) do_abs(2'($urandom_range(3)), POS_MAX, POS_MAX, rnd24());
    repeat (40) do_abs(2'($urandom_range(3)), POS_MIN, POS_MIN, rnd24());
  endtask

  // Receiver holds off long enough for both result and input registers to
  // fill, while the sender keeps offering words.
  task automatic test_backpressure();
    wait_drained();
    hold_request++;
    steady = 1'b1;
    repeat (16) do_pulse(pick_axis());
    steady = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_registers();
    program_regs(mspt_pkg::REG_W'($urandom), mspt_pkg::REG_W'($urandom),
                 mspt_pkg::REG_W'($urandom_range(400)));
    run_random(120);
    program_regs(mspt_pkg::REG_W'($urandom), mspt_pkg::REG_W'($urandom),
                 mspt_pkg::REG_W'($urandom));
    run_random(90);
  endtask

  // ---------------------------------------------------------------- checker
  task automatic compare_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : rx_side
    int             hold_left;
    int             hold_seen;
    mspt_pkg::res_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
      hold_seen = hold_request;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_reports.size() == 0) begin
          $display("%0t: result word with none expected, position %0d",
                   $time, axis_position);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          compare_field("enable_mask", 32'(want.enable_mask), 32'(enable_mask));
          compare_field("direction_mask", 32'(want.direction_mask),
                        32'(direction_mask));
          compare_field("axis_position", 32'(want.axis_position), 32'(axis_position));
          compare_field("axis_at_target", 32'(want.axis_at_target),
                        32'(axis_at_target));
        end
      end
      if (hold_request != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_request;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && $urandom_range(99) < 27;
      end
    end
  end

  // Watchdog: too long without a word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("tb_multi_axis_step_position_tracker: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_steady_stream();
    test_register_extremes();
    test_backlash_full_scale();
    test_backpressure();
    test_random_registers();
    wait_drained();
    repeat (8) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, expected_reports.size());
    end
    $display("Sent %0d words (set %0d, move %0d, scan %0d, pulse %0d), checked %0d",
             n_words, kind_count[mspt_pkg::KIND_ABS_SET],
             kind_count[mspt_pkg::KIND_REL_MOVE], kind_count[mspt_pkg::KIND_SCAN],
             kind_count[mspt_pkg::KIND_PULSE], n_checked);
    $display("Registers at reset, zero, full-scale and random; targets clamped both ends");
    if (errors == 0 && expected_reports.size() == 0) begin
      $display("tb_multi_axis_step_position_tracker: clean");
    end else begin
      $display("tb_multi_axis_step_position_tracker: errors");
    end
    $finish;
  end

endmodule
